FILE: hdl/stq_pkg.sv
// Shared types, codes and constants of the sorted timer event queue.
`timescale 1ns / 1ps
package stq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH  = 16;
  localparam int DEFAULT_TASK_ID_BITS = 8;

  localparam logic [31:0] EXPIRY_WINDOW_RST = 32'h0FFF_0000;
  localparam logic [15:0] MAX_RELOAD_RST    = 16'hFFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RELOAD    = 1'b1;

  typedef enum logic [2:0] {
    CMD_AT         = 3'd0,
    CMD_AFTER      = 3'd1,
    CMD_CANCEL     = 3'd2,
    CMD_CANCEL_ALL = 3'd3,
    CMD_TICK       = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_DUE    = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_code_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  task_id;
    logic [31:0] time_value;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  due_task;
    logic [15:0] reload_delay;
    logic        timer_running;
    logic [4:0]  pending_count;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_IDX   = 2'd0,
    RD_BELOW = 2'd1,
    RD_ABOVE = 2'd2,
    RD_HEAD  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    clear_count;
    logic    scan_start;
    logic    idx_inc;
    logic    pos_from_idx;
    logic    pos_from_count;
    logic    j_from_count;
    logic    j_from_idx;
    logic    j_from_head;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_shu;
    logic    wr_shd;
    logic    wr_ins;
    logic    cnt_dec;
    logic    emit_due;
    logic    emit_status;
    logic    emit_err;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sched;
    logic is_cancel;
    logic is_cancel_all;
    logic full;
    logic count_zero;
    logic idx_last;
    logic hit;
    logic shu_last;
    logic shd_done;
    logic expired;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hdl/stq_dp.sv
// Datapath: queue memory, pointers, configuration registers and result register.
`timescale 1ns / 1ps
module stq_dp #(
  parameter int QUEUE_DEPTH  = stq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int TASK_ID_BITS = stq_pkg::DEFAULT_TASK_ID_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stq_pkg::in_item_t              in_item,
  input  logic                           cfg_valid,
  input  logic [stq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  stq_pkg::dp_cmd_t               cmd,
  output stq_pkg::dp_sts_t               sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output stq_pkg::out_item_t             out_item
);
  import stq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = TASK_ID_BITS;
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);
  localparam logic [CW-1:0] CNT_DEPTH = CW'(QUEUE_DEPTH);

  logic [31:0]   due_mem [QUEUE_DEPTH];
  logic [IW-1:0] id_mem  [QUEUE_DEPTH];

  logic [2:0]    cmd_r;
  logic [IW-1:0] id_r;
  logic [31:0]   due_r;
  logic [31:0]   now_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] j_r;
  logic [31:0]   window_r;
  logic [15:0]   max_reload_r;
  logic [31:0]   rd_due_r;
  logic [IW-1:0] rd_id_r;
  logic          out_valid_r;
  out_item_t     out_item_r;

  logic [15:0]   id_wide;
  logic [IW-1:0] id_in;
  logic [31:0]   due_nxt;
  logic [15:0]   rd_id_wide;
  logic [CW-1:0] rd_ptr;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] wr_ptr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [31:0]   wr_due;
  logic [IW-1:0] wr_id;
  logic [31:0]   head_dist;
  logic [31:0]   new_dist;
  logic [15:0]   reload;
  logic          out_free;
  out_item_t     out_nxt;

  assign id_wide    = 16'(in_item.task_id);
  assign id_in      = id_wide[IW-1:0];
  assign due_nxt    = (in_item.cmd == CMD_AT) ? in_item.time_value
                                               : in_item.now_time + in_item.time_value;
  assign rd_id_wide = 16'(rd_id_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:   rd_ptr = idx_r;
      RD_BELOW: rd_ptr = j_r - CNT_ONE;
      RD_ABOVE: rd_ptr = j_r + CNT_ONE;
      default:  rd_ptr = '0;
    endcase
  end
  assign rd_addr = rd_ptr[AW-1:0];

  assign wr_en   = cmd.wr_shu | cmd.wr_shd | cmd.wr_ins;
  assign wr_ptr  = cmd.wr_ins ? pos_r : j_r;
  assign wr_addr = wr_ptr[AW-1:0];
  assign wr_due  = cmd.wr_ins ? due_r : rd_due_r;
  assign wr_id   = cmd.wr_ins ? id_r : rd_id_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      due_mem[wr_addr] <= wr_due;
      id_mem[wr_addr]  <= wr_id;
    end
    if (cmd.rd_en) begin
      rd_due_r <= due_mem[rd_addr];
      rd_id_r  <= id_mem[rd_addr];
    end
  end

  assign head_dist = rd_due_r - now_r;
  assign new_dist  = due_r - now_r;
  assign reload    = (head_dist > {16'd0, max_reload_r}) ? max_reload_r : head_dist[15:0];
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    sts.is_sched      = (cmd_r == CMD_AT) || (cmd_r == CMD_AFTER);
    sts.is_cancel     = (cmd_r == CMD_CANCEL);
    sts.is_cancel_all = (cmd_r == CMD_CANCEL_ALL);
    sts.full          = (count_r == CNT_DEPTH);
    sts.count_zero    = (count_r == '0);
    sts.idx_last      = (idx_r + CNT_ONE == count_r);
    sts.hit           = sts.is_sched ? (new_dist < head_dist) : (rd_id_r == id_r);
    sts.shu_last      = (j_r == pos_r + CNT_ONE);
    sts.shd_done      = (j_r + CNT_ONE >= count_r);
    sts.expired       = (head_dist > window_r);
    sts.out_free      = out_free;
  end

  always_comb begin
    out_nxt = '0;
    if (cmd.emit_due) begin
      out_nxt.kind          = KIND_DUE;
      out_nxt.due_task      = rd_id_wide[7:0];
      out_nxt.pending_count = 5'(count_r - CNT_ONE);
    end else if (cmd.emit_status) begin
      out_nxt.kind          = KIND_STATUS;
      out_nxt.timer_running = (count_r != '0);
      out_nxt.reload_delay  = (count_r != '0) ? reload : 16'd0;
      out_nxt.pending_count = 5'(count_r);
      out_nxt.last          = 1'b1;
    end else begin
      out_nxt.kind          = KIND_ERROR;
      out_nxt.pending_count = 5'(count_r);
      out_nxt.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_item.cmd;
      id_r  <= id_in;
      due_r <= due_nxt;
      now_r <= in_item.now_time;
    end
    if (cmd.emit_due || cmd.emit_status || cmd.emit_err) begin
      out_item_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      pos_r        <= '0;
      j_r          <= '0;
      out_valid_r  <= 1'b0;
      window_r     <= EXPIRY_WINDOW_RST;
      max_reload_r <= MAX_RELOAD_RST;
    end else begin
      if (cmd.clear_count) begin
        count_r <= '0;
      end else if (cmd.wr_ins) begin
        count_r <= count_r + CNT_ONE;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CNT_ONE;
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CNT_ONE;
      end
      if (cmd.pos_from_idx) begin
        pos_r <= idx_r;
      end else if (cmd.pos_from_count) begin
        pos_r <= count_r;
      end
      if (cmd.j_from_count) begin
        j_r <= count_r;
      end else if (cmd.j_from_idx) begin
        j_r <= idx_r;
      end else if (cmd.j_from_head) begin
        j_r <= '0;
      end else if (cmd.wr_shu) begin
        j_r <= j_r - CNT_ONE;
      end else if (cmd.wr_shd) begin
        j_r <= j_r + CNT_ONE;
      end
      if (cmd.emit_due || cmd.emit_status || cmd.emit_err) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_EXPIRY_WINDOW: window_r     <= cfg_data;
          CFG_MAX_RELOAD:    max_reload_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hdl/stq_ctrl.sv
// Controller: sequences scan, shift, insert, expiry walk and result emission.
`timescale 1ns / 1ps
module stq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  stq_pkg::dp_sts_t sts,
  output stq_pkg::dp_cmd_t cmd
);
  import stq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHU_RD,
    S_SHU_WR,
    S_INS,
    S_SHD_RD,
    S_SHD_WR,
    S_EXP_RD,
    S_EXP_CHK,
    S_ERR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_sched) begin
          if (sts.full) begin
            state_nxt = S_ERR;
          end else if (sts.count_zero) begin
            cmd.pos_from_count = 1'b1;
            state_nxt          = S_INS;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN_RD;
          end
        end else if (sts.is_cancel) begin
          if (sts.count_zero) begin
            state_nxt = S_EXP_RD;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN_RD;
          end
        end else if (sts.is_cancel_all) begin
          cmd.clear_count = 1'b1;
          state_nxt       = S_EXP_RD;
        end else begin
          state_nxt = S_EXP_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.hit) begin
          if (sts.is_sched) begin
            cmd.pos_from_idx = 1'b1;
            cmd.j_from_count = 1'b1;
            state_nxt        = S_SHU_RD;
          end else begin
            cmd.j_from_idx = 1'b1;
            state_nxt      = S_SHD_RD;
          end
        end else if (sts.idx_last) begin
          if (sts.is_sched) begin
            cmd.pos_from_count = 1'b1;
            state_nxt          = S_INS;
          end else begin
            state_nxt = S_EXP_RD;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SHU_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BELOW;
        state_nxt  = S_SHU_WR;
      end
      S_SHU_WR: begin
        cmd.wr_shu = 1'b1;
        state_nxt  = sts.shu_last ? S_INS : S_SHU_RD;
      end
      S_INS: begin
        cmd.wr_ins = 1'b1;
        state_nxt  = S_EXP_RD;
      end
      S_SHD_RD: begin
        if (sts.shd_done) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_EXP_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ABOVE;
          state_nxt  = S_SHD_WR;
        end
      end
      S_SHD_WR: begin
        cmd.wr_shd = 1'b1;
        state_nxt  = S_SHD_RD;
      end
      S_EXP_RD: begin
        if (sts.count_zero) begin
          if (sts.out_free) begin
            cmd.emit_status = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_nxt  = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (sts.out_free) begin
          if (sts.expired) begin
            cmd.emit_due    = 1'b1;
            cmd.j_from_head = 1'b1;
            state_nxt       = S_SHD_RD;
          end else begin
            cmd.emit_status = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

FILE: hdl/sorted_timer_event_queue.sv
// Top level of the sorted timer event queue.
//
//  channel | ports                            | direction | item
//  in      | in_valid, in_ready, in_item      | input     | command, task id, time, now
//  out     | out_valid, out_ready, out_item   | output    | due task, status or error
//  cfg     | cfg_valid, cfg_ready, cfg_index, | input     | expiry window, max reload
//          | cfg_data                         |           |
//
// One item at a time. An item is loaded and dispatched; a schedule or a cancel then
// scans the queue, moves entries, and inserts the new entry or removes the match;
// then each expired entry at the head is emitted as due and removed before a status
// result. A cancel-all empties the queue first. The queue memory has registered reads.
// Reset is synchronous and active low; the queue memory is not cleared.
// A stalled result holds the block only when the next result is ready to be loaded.
`timescale 1ns / 1ps
module sorted_timer_event_queue #(
  parameter int QUEUE_DEPTH  = stq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int TASK_ID_BITS = stq_pkg::DEFAULT_TASK_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  stq_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stq_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [stq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import stq_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready = 1'b1;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  stq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready again right after taking an item");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.emit_due || dp_cmd.emit_status || dp_cmd.emit_err) |-> dp_sts.out_free)
    else $error("result loaded over an untaken result");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.wr_ins |-> !dp_sts.full)
    else $error("insert into a full queue");

  a_no_remove_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.cnt_dec |-> !dp_sts.count_zero)
    else $error("removal from an empty queue");

endmodule
